// ===== rtl/pbm_pkg.sv =====
package pbm_pkg;

   localparam int CHANNEL_COUNT_DEFAULT = 3;
   localparam int FIELD_CHANNELS        = 3;
   localparam int NUM_W                 = 27;
   localparam int REM_W                 = 26;
   localparam int DEN_W                 = 17;
   localparam int Q_W                   = 9;
   localparam int LANE_STAGES           = 2 + Q_W;

   typedef enum logic [2:0] {
      MODE_HARD_MIX     = 3'd0,
      MODE_OVERLAY      = 3'd1,
      MODE_PIN_LIGHT    = 3'd2,
      MODE_HARD_LIGHT   = 3'd3,
      MODE_SOFT_LIGHT   = 3'd4,
      MODE_LINEAR_LIGHT = 3'd5,
      MODE_VIVID_LIGHT  = 3'd6
   } blend_mode_type;

   typedef struct packed {
      logic [7:0] base_red;
      logic [7:0] base_green;
      logic [7:0] base_blue;
      logic [7:0] top_red;
      logic [7:0] top_green;
      logic [7:0] top_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] mixed_red;
      logic [7:0] mixed_green;
      logic [7:0] mixed_blue;
   } rsp_type;

   typedef logic [7:0] sqrt_table_type [256];

   function automatic sqrt_table_type build_sqrt_table();
      sqrt_table_type tbl;
      int n;
      int r;
      for (int i = 0; i < 256; i++) begin
         n = 255 * i;
         r = 0;
         for (int f = 0; f < 256; f++) begin
            if ((f + 1) * (f + 1) <= n) begin
               r = f + 1;
            end
         end
         if (n - r * r > r) begin
            r = r + 1;
         end
         tbl[i] = 8'(r);
      end
      return tbl;
   endfunction

   localparam sqrt_table_type SQRT_TABLE = build_sqrt_table();

endpackage

// ===== rtl/pbm_lane.sv =====
module pbm_lane (
   input  logic                             clock,
   input  logic [pbm_pkg::LANE_STAGES-1:0]  en,
   input  pbm_pkg::blend_mode_type          mode,
   input  logic [7:0]                       base,
   input  logic [7:0]                       top,
   output logic [7:0]                       mixed
);

   localparam int NUM_W = pbm_pkg::NUM_W;
   localparam int REM_W = pbm_pkg::REM_W;
   localparam int DEN_W = pbm_pkg::DEN_W;
   localparam int Q_W   = pbm_pkg::Q_W;

   logic [7:0]              a_ff, b_ff;
   pbm_pkg::blend_mode_type mode_ff;
   logic [15:0]             ab_ff, ab_in;
   logic [15:0]             inv_ff, inv_in;
   logic [13:0]             sel_ff, sel_in;
   logic [15:0]             paa;
   logic [7:0]              tdiff;

   always_comb begin
      ab_in  = 16'(base) * 16'(top);
      inv_in = 16'(8'd255 - base) * 16'(8'd255 - top);
      paa    = 16'(base) * 16'(8'd255 - base);
      tdiff  = pbm_pkg::SQRT_TABLE[base] - base;
      sel_in = top[7] ? {6'd0, tdiff} : paa[13:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff    <= base;
         b_ff    <= top;
         mode_ff <= mode;
         ab_ff   <= ab_in;
         inv_ff  <= inv_in;
         sel_ff  <= sel_in;
      end
   end

   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [8:0]       d9;
   logic signed [14:0]      sel_s;
   logic signed [23:0]      prod;
   logic signed [NUM_W-1:0] aw, bw, abw, invw, prodw, v;
   logic                    direct;
   logic                    hi;

   always_comb begin
      d9     = signed'(9'({b_ff, 1'b0}) - 9'd255);
      sel_s  = signed'({1'b0, sel_ff});
      prod   = d9 * sel_s;
      prodw  = NUM_W'(prod);
      aw     = NUM_W'(a_ff);
      bw     = NUM_W'(b_ff);
      abw    = NUM_W'(ab_ff);
      invw   = NUM_W'(inv_ff);
      direct = 1'b0;
      v      = '0;
      num_in = '0;
      den_in = DEN_W'(510);
      hi     = (mode_ff == pbm_pkg::MODE_OVERLAY) ? a_ff[7] : b_ff[7];
      case (mode_ff)
         pbm_pkg::MODE_HARD_MIX: begin
            direct = 1'b1;
            v = (({1'b0, a_ff} + {1'b0, b_ff}) < 9'd255) ? NUM_W'(0) : NUM_W'(255);
         end
         pbm_pkg::MODE_OVERLAY, pbm_pkg::MODE_HARD_LIGHT: begin
            if (hi) begin
               num_in = NUM_W'(130305 - 4 * invw);
            end else begin
               num_in = NUM_W'(4 * abw + 255);
            end
         end
         pbm_pkg::MODE_PIN_LIGHT: begin
            direct = 1'b1;
            if (b_ff <= 8'd128) begin
               v = (aw < 2 * bw) ? aw : NUM_W'(2 * bw);
            end else begin
               v = (aw > 2 * bw - 255) ? aw : NUM_W'(2 * bw - 255);
            end
         end
         pbm_pkg::MODE_SOFT_LIGHT: begin
            if (!b_ff[7]) begin
               num_in = NUM_W'(2 * (aw * 65025 + prodw) + 65025);
               den_in = DEN_W'(130050);
            end else begin
               num_in = NUM_W'(2 * (255 * aw + prodw) + 255);
            end
         end
         pbm_pkg::MODE_LINEAR_LIGHT: begin
            direct = 1'b1;
            v = NUM_W'(aw + 2 * bw - 255);
         end
         pbm_pkg::MODE_VIVID_LIGHT: begin
            if (b_ff == 8'd0) begin
               direct = 1'b1;
               v = '0;
            end else if (b_ff <= 8'd128) begin
               num_in = NUM_W'(510 * (2 * bw - 255 + aw) + 2 * bw);
               den_in = DEN_W'(4 * bw);
            end else if (b_ff == 8'd255) begin
               direct = 1'b1;
               v = (a_ff == 8'd0) ? NUM_W'(0) : NUM_W'(255);
            end else begin
               num_in = NUM_W'(510 * aw + 2 * (255 - bw));
               den_in = DEN_W'(4 * (255 - bw));
            end
         end
         default: begin
            direct = 1'b1;
            v = aw;
         end
      endcase
      if (direct) begin
         num_in = NUM_W'(2 * v + 1);
         den_in = DEN_W'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   logic [REM_W-1:0] rem_ff [Q_W];
   logic [REM_W-1:0] rem_in [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [Q_W-1:0]   q_in   [Q_W];
   logic [DEN_W-1:0] dd_ff  [Q_W];
   logic [DEN_W-1:0] dd_in  [Q_W];
   logic             neg_ff [Q_W];
   logic             neg_in [Q_W];
   logic             sat_ff [Q_W];
   logic             sat_in [Q_W];
   logic [REM_W-1:0] rem_src [Q_W];
   logic [Q_W-1:0]   q_src   [Q_W];
   logic [REM_W-1:0] shifted [Q_W];

   always_comb begin
      for (int i = 0; i < Q_W; i++) begin
         if (i == 0) begin
            neg_in[i]  = num_ff[NUM_W-1];
            sat_in[i]  = !num_ff[NUM_W-1] &&
                         (unsigned'(num_ff) >= (NUM_W'(den_ff) << Q_W));
            rem_src[i] = num_ff[NUM_W-1] ? '0 : num_ff[REM_W-1:0];
            q_src[i]   = '0;
            dd_in[i]   = den_ff;
         end else begin
            neg_in[i]  = neg_ff[i-1];
            sat_in[i]  = sat_ff[i-1];
            rem_src[i] = rem_ff[i-1];
            q_src[i]   = q_ff[i-1];
            dd_in[i]   = dd_ff[i-1];
         end
         shifted[i] = REM_W'(dd_in[i]) << (Q_W - 1 - i);
         if (rem_src[i] >= shifted[i]) begin
            rem_in[i] = rem_src[i] - shifted[i];
            q_in[i]   = q_src[i] | (Q_W'(1) << (Q_W - 1 - i));
         end else begin
            rem_in[i] = rem_src[i];
            q_in[i]   = q_src[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Q_W; i++) begin
         if (en[2+i]) begin
            rem_ff[i] <= rem_in[i];
            q_ff[i]   <= q_in[i];
            dd_ff[i]  <= dd_in[i];
            neg_ff[i] <= neg_in[i];
            sat_ff[i] <= sat_in[i];
         end
      end
   end

   always_comb begin
      if (neg_ff[Q_W-1]) begin
         mixed = 8'd0;
      end else if (sat_ff[Q_W-1] || q_ff[Q_W-1][Q_W-1]) begin
         mixed = 8'd255;
      end else begin
         mixed = q_ff[Q_W-1][7:0];
      end
   end

endmodule

// ===== rtl/pixel_blend_mode_unit.sv =====
// Throughput: one transaction per cycle unless rsp_stall holds the pipeline; each lane runs a product stage,
// a numerator stage and a nine-stage restoring divider, one quotient bit per stage.
// Reset (synchronous, active high) empties the pipeline and sets blend_mode to hard mix.
module pixel_blend_mode_unit #(
   parameter int CHANNEL_COUNT = pbm_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pbm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pbm_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_write_data
);

   localparam int STAGES = pbm_pkg::LANE_STAGES;
   localparam int FC     = pbm_pkg::FIELD_CHANNELS;

   pbm_pkg::blend_mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pbm_pkg::MODE_HARD_MIX;
      end else if (csr_write_enable) begin
         mode_ff <= pbm_pkg::blend_mode_type'(csr_write_data);
      end
   end

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] adv;
   logic              adv_out;
   logic              rsp_valid_ff;
   pbm_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   always_comb begin
      adv_out = !rsp_valid_ff || !rsp_stall;
      adv[STAGES-1] = !vld_ff[STAGES-1] || adv_out;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (adv_out) begin
            rsp_valid_ff <= vld_ff[STAGES-1];
         end
      end
   end

   logic [7:0] base  [FC];
   logic [7:0] top   [FC];
   logic [7:0] mixed [FC];

   always_comb begin
      base[0] = req_data.base_red;
      base[1] = req_data.base_green;
      base[2] = req_data.base_blue;
      top[0]  = req_data.top_red;
      top[1]  = req_data.top_green;
      top[2]  = req_data.top_blue;
   end

   for (genvar j = 0; j < FC; j++) begin : g_lane
      if (j < CHANNEL_COUNT) begin : g_on
         pbm_lane u_lane (
            .clock (clock),
            .en    (adv),
            .mode  (mode_ff),
            .base  (base[j]),
            .top   (top[j]),
            .mixed (mixed[j])
         );
      end else begin : g_off
         assign mixed[j] = 8'd0;
      end
   end

   always_comb begin
      rsp_data_in.mixed_red   = mixed[0];
      rsp_data_in.mixed_green = mixed[1];
      rsp_data_in.mixed_blue  = mixed[2];
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
